### design/sfh_pkg.sv
// Shared constants and codes of the segregated-fit heap allocator.
`default_nettype none
package sfh_pkg;
  localparam int OP_W   = 2;
  localparam int SIZE_W = 21;
  localparam int ADDR_W = 20;
  localparam int ST_W   = 2;

  localparam int NUM_CLASSES = 20;
  localparam int BASE_BYTES  = (NUM_CLASSES + 4) * 4;
  localparam int MIN_BLOCK   = 16;

  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;
endpackage
`default_nettype wire

### design/sfh_if.sv
// Request and result channel interfaces of the heap allocator.
`default_nettype none
interface sfh_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfh_pkg::OP_W-1:0]   opcode;
  logic [sfh_pkg::SIZE_W-1:0] request_size;
  logic [sfh_pkg::ADDR_W-1:0] block_address;
  modport source (output valid, output opcode, output request_size,
                  output block_address, input ready);
  modport sink (input valid, input opcode, input request_size,
                input block_address, output ready);
endinterface

interface sfh_out_if;
  logic                      valid;
  logic                      ready;
  logic [sfh_pkg::ADDR_W-1:0] result_address;
  logic [sfh_pkg::ST_W-1:0]   status;
  modport source (output valid, output result_address, output status, input ready);
  modport sink (input valid, input result_address, input status, output ready);
endinterface
`default_nettype wire

### design/sfh_heap_mem.sv
// Heap word memory: byte-addressed, one access per cycle, registered read.
`default_nettype none
module sfh_heap_mem #(
  parameter int HEAP_BYTES = 1048576
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] addr,
  input  wire logic [AW-1:0] wdata,
  output logic      [AW-1:0] rdata
);
  localparam int L     = $clog2(HEAP_BYTES);
  localparam int AW    = (L + 3 > 23) ? L + 3 : 23;
  localparam int DW    = L + 1;
  localparam int IW    = L - 2;
  localparam int DEPTH = HEAP_BYTES / 4;
  localparam logic [AW-1:0] HEAP_W = AW'(HEAP_BYTES);

  logic [DW-1:0] ram [DEPTH];
  logic [DW-1:0] rdata_r;
  logic          oob_r;
  logic          oob;
  logic [IW-1:0] idx;

  assign oob = (addr >= HEAP_W);
  assign idx = addr[IW+1:2];

  always_ff @(posedge clk) begin
    if (wr_en && !oob) begin
      ram[idx] <= wdata[DW-1:0];
    end
    if (rd_en) begin
      rdata_r <= ram[idx];
      oob_r   <= oob;
    end
  end

  // out-of-range reads return zero
  assign rdata = oob_r ? '0 : AW'(rdata_r);
endmodule
`default_nettype wire

### design/sfh_ctrl.sv
// Allocator sequencer: init, first-fit search, split, grow, coalesce, list ops.
`default_nettype none
module sfh_ctrl #(
  parameter int HEAP_BYTES  = 1048576,
  parameter int CHUNK_BYTES = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [sfh_pkg::OP_W-1:0]   in_opcode,
  input  wire logic [sfh_pkg::SIZE_W-1:0] in_size,
  input  wire logic [sfh_pkg::ADDR_W-1:0] in_addr,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [sfh_pkg::ADDR_W-1:0] out_addr,
  output logic      [sfh_pkg::ST_W-1:0]   out_status,
  output logic                            mem_rd,
  output logic                            mem_wr,
  output logic      [AW-1:0]              mem_addr,
  output logic      [AW-1:0]              mem_wdata,
  input  wire logic [AW-1:0]              mem_rdata
);
  localparam int L  = $clog2(HEAP_BYTES);
  localparam int AW = (L + 3 > 23) ? L + 3 : 23;
  localparam int BW = L - 1;
  localparam logic [AW-1:0] HEAP_W  = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] CHUNK_W = AW'(CHUNK_BYTES);
  localparam logic [BW-1:0] BUDGET0 = BW'(HEAP_BYTES / 4);
  localparam logic [AW-1:0] C1  = AW'(1);
  localparam logic [AW-1:0] C4  = AW'(4);
  localparam logic [AW-1:0] C8  = AW'(8);
  localparam logic [AW-1:0] C9  = AW'(9);
  localparam logic [AW-1:0] C15 = AW'(15);
  localparam logic [AW-1:0] C16 = AW'(sfh_pkg::MIN_BLOCK);
  localparam logic [AW-1:0] BASE_W = AW'(sfh_pkg::BASE_BYTES);
  localparam logic [4:0] LAST_CLASS = 5'(sfh_pkg::NUM_CLASSES - 1);
  localparam logic [4:0] LAST_HEAD  = 5'(sfh_pkg::NUM_CLASSES);

  localparam logic [6:0] S_IDLE = 7'd0,  S_DONE = 7'd1,  S_I0 = 7'd2,   S_I1 = 7'd3,
                         S_I2 = 7'd4,    S_I3 = 7'd5,    S_G0 = 7'd6,   S_G1 = 7'd7,
                         S_G2 = 7'd8,    S_M0 = 7'd9,    S_M1 = 7'd10,  S_M2 = 7'd11,
                         S_M3 = 7'd12,   S_M4 = 7'd13,   S_M5 = 7'd14,  S_A0 = 7'd15,
                         S_A1 = 7'd16,   S_A2 = 7'd17,   S_A3 = 7'd18,  S_A4 = 7'd19,
                         S_A5 = 7'd20,   S_A6 = 7'd21,   S_B0 = 7'd22,  S_B1 = 7'd23,
                         S_B2 = 7'd24,   S_B3 = 7'd25,   S_B4 = 7'd26,  S_B5 = 7'd27,
                         S_C0 = 7'd28,   S_C1 = 7'd29,   S_C2 = 7'd30,  S_C3 = 7'd31,
                         S_C4 = 7'd32,   S_C5 = 7'd33,   S_C6 = 7'd34,  S_C7 = 7'd35,
                         S_C8 = 7'd36,   S_C9 = 7'd37,   S_C10 = 7'd38, S_C11 = 7'd39,
                         S_C12 = 7'd40,  S_D0 = 7'd41,   S_D1 = 7'd42,  S_D2 = 7'd43,
                         S_D3 = 7'd44,   S_MDONE = 7'd45, S_P0 = 7'd46, S_P1 = 7'd47,
                         S_P2 = 7'd48,   S_P3 = 7'd49,   S_P5 = 7'd50,  S_P6 = 7'd51,
                         S_P7 = 7'd52,   S_P8 = 7'd53,   S_P9 = 7'd54,  S_Q0 = 7'd55,
                         S_Q1 = 7'd56,   S_Q2 = 7'd57,   S_Q3 = 7'd58,  S_Q4 = 7'd59,
                         S_Q5 = 7'd60,   S_F0 = 7'd61,   S_F1 = 7'd62,  S_F2 = 7'd63,
                         S_NOFIT = 7'd64, S_K0 = 7'd65,  S_K1 = 7'd66,  S_K2 = 7'd67,
                         S_K3 = 7'd68,   S_K4 = 7'd69,   S_K5 = 7'd70,  S_K6 = 7'd71,
                         S_K7 = 7'd72,   S_K8 = 7'd73,   S_R0 = 7'd74,  S_R1 = 7'd75,
                         S_R2 = 7'd76,   S_R3 = 7'd77;

  function automatic logic [4:0] class_of(input logic [AW-1:0] sz);
    logic [4:0] c;
    c = LAST_CLASS;
    for (int k = 22; k >= 4; k--) begin
      if (sz <= AW'(64'd1 << k)) c = 5'(k - 4);
    end
    return c;
  endfunction

  logic [6:0]                  state_r, state_nxt, ret_r, ret_nxt;
  logic [sfh_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [AW-1:0]               bp_r, bp_nxt, x_r, x_nxt, acc_r, acc_nxt, tmp_r, tmp_nxt;
  logic [AW-1:0]               csize_r, csize_nxt, v_r, v_nxt, slot_r, slot_nxt;
  logic [AW-1:0]               pre_r, pre_nxt, head_r, head_nxt, top_r, top_nxt;
  logic [AW-1:0]               asize_r, asize_nxt, bytes_r, bytes_nxt;
  logic [4:0]                  cls_r, cls_nxt, cnt_r, cnt_nxt;
  logic [BW-1:0]               budget_r, budget_nxt;
  logic                        pa_r, pa_nxt, split_r, split_nxt;
  logic [sfh_pkg::ADDR_W-1:0]  res_r, res_nxt, out_addr_r, out_addr_nxt;
  logic [sfh_pkg::ST_W-1:0]    status_r, status_nxt, out_status_r, out_status_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [AW-1:0] t, size_w, s15, ext, wp1;

  assign t      = {mem_rdata[AW-1:3], 3'b000};
  assign size_w = AW'(in_size);
  assign s15    = size_w + C15;
  assign ext    = (asize_r > CHUNK_W) ? asize_r : CHUNK_W;
  assign wp1    = (ext >> 2) + C1;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_addr   = out_addr_r;
  assign out_status = out_status_r;

  always_comb begin
    logic [AW-1:0] cw;
    cw = (CHUNK_W >> 2) + C1;
    state_nxt = state_r;  ret_nxt = ret_r;  op_nxt = op_r;
    bp_nxt = bp_r;  x_nxt = x_r;  acc_nxt = acc_r;  tmp_nxt = tmp_r;
    csize_nxt = csize_r;  v_nxt = v_r;  slot_nxt = slot_r;  pre_nxt = pre_r;
    head_nxt = head_r;  top_nxt = top_r;  asize_nxt = asize_r;  bytes_nxt = bytes_r;
    cls_nxt = cls_r;  cnt_nxt = cnt_r;  budget_nxt = budget_r;  pa_nxt = pa_r;
    split_nxt = split_r;  res_nxt = res_r;  status_nxt = status_r;
    out_valid_nxt = out_valid_r;  out_addr_nxt = out_addr_r;
    out_status_nxt = out_status_r;
    mem_rd = 1'b0;  mem_wr = 1'b0;  mem_addr = '0;  mem_wdata = '0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_opcode;
          res_nxt = '0;
          status_nxt = sfh_pkg::ST_DONE;
          state_nxt = S_DONE;
          case (in_opcode)
            sfh_pkg::OP_INIT: begin
              top_nxt = BASE_W;
              cnt_nxt = '0;
              state_nxt = S_I0;
            end
            sfh_pkg::OP_ALLOC: begin
              if (in_size == '0) begin
                status_nxt = sfh_pkg::ST_ZERO;
              end else if (top_r == '0) begin
                status_nxt = sfh_pkg::ST_NOSPACE;
              end else begin
                asize_nxt = (size_w <= C8) ? C16 : {s15[AW-1:3], 3'b000};
                cls_nxt = class_of((size_w <= C8) ? C16 : {s15[AW-1:3], 3'b000});
                budget_nxt = BUDGET0;
                state_nxt = S_F0;
              end
            end
            sfh_pkg::OP_FREE: begin
              if (in_addr != '0 && top_r != '0) begin
                bp_nxt = AW'(in_addr);
                state_nxt = S_R0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt = res_r;
          out_status_nxt = status_r;
          state_nxt = S_IDLE;
        end
      end
      // layout: class heads and padding, prologue, epilogue
      S_I0: begin
        mem_wr = 1'b1;  mem_addr = AW'({cnt_r, 2'b00});
        cnt_nxt = 5'(cnt_r + 5'd1);
        if (cnt_r == LAST_HEAD) state_nxt = S_I1;
      end
      S_I1: begin
        mem_wr = 1'b1;  mem_addr = BASE_W - C4 - C8;  mem_wdata = C9;
        state_nxt = S_I2;
      end
      S_I2: begin
        mem_wr = 1'b1;  mem_addr = BASE_W - C8;  mem_wdata = C9;
        state_nxt = S_I3;
      end
      S_I3: begin
        mem_wr = 1'b1;  mem_addr = BASE_W - C4;  mem_wdata = C1;
        bytes_nxt = {cw[AW-3:1], 3'b000};
        state_nxt = S_G0;
      end
      // heap growth
      S_G0: begin
        if (bytes_r > HEAP_W || top_r > HEAP_W - bytes_r) begin
          res_nxt = '0;
          status_nxt = sfh_pkg::ST_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          bp_nxt = top_r;
          top_nxt = top_r + bytes_r;
          mem_wr = 1'b1;  mem_addr = top_r - C4;  mem_wdata = bytes_r;
          state_nxt = S_G1;
        end
      end
      S_G1: begin
        mem_wr = 1'b1;  mem_addr = bp_r + bytes_r - C8;  mem_wdata = bytes_r;
        state_nxt = S_G2;
      end
      S_G2: begin
        mem_wr = 1'b1;  mem_addr = bp_r + bytes_r - C4;  mem_wdata = C1;
        state_nxt = S_M0;
      end
      // coalesce: probe neighbors
      S_M0: begin mem_rd = 1'b1;  mem_addr = bp_r - C8;  state_nxt = S_M1; end
      S_M1: begin
        x_nxt = bp_r - t;
        mem_rd = 1'b1;  mem_addr = bp_r - t - C4;  state_nxt = S_M2;
      end
      S_M2: begin mem_rd = 1'b1;  mem_addr = x_r + t - C8;  state_nxt = S_M3; end
      S_M3: begin
        pa_nxt = mem_rdata[0];
        mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_M4;
      end
      S_M4: begin
        acc_nxt = t;
        mem_rd = 1'b1;  mem_addr = bp_r + t - C4;  state_nxt = S_M5;
      end
      S_M5: begin
        if (pa_r && mem_rdata[0]) begin
          x_nxt = bp_r;  ret_nxt = S_MDONE;  state_nxt = S_Q0;
        end else if (pa_r) begin
          state_nxt = S_A0;
        end else if (mem_rdata[0]) begin
          state_nxt = S_B0;
        end else begin
          state_nxt = S_C0;
        end
      end
      // next neighbor free
      S_A0: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_A1; end
      S_A1: begin x_nxt = bp_r + t;  ret_nxt = S_A2;  state_nxt = S_P0; end
      S_A2: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_A3; end
      S_A3: begin mem_rd = 1'b1;  mem_addr = bp_r + t - C4;  state_nxt = S_A4; end
      S_A4: begin
        acc_nxt = acc_r + t;
        mem_wr = 1'b1;  mem_addr = bp_r - C4;  mem_wdata = acc_r + t;
        state_nxt = S_A5;
      end
      S_A5: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_A6; end
      S_A6: begin
        mem_wr = 1'b1;  mem_addr = bp_r + t - C8;  mem_wdata = acc_r;
        x_nxt = bp_r;  ret_nxt = S_MDONE;  state_nxt = S_Q0;
      end
      // previous neighbor free
      S_B0: begin mem_rd = 1'b1;  mem_addr = bp_r - C8;  state_nxt = S_B1; end
      S_B1: begin x_nxt = bp_r - t;  ret_nxt = S_B2;  state_nxt = S_P0; end
      S_B2: begin mem_rd = 1'b1;  mem_addr = bp_r - C8;  state_nxt = S_B3; end
      S_B3: begin mem_rd = 1'b1;  mem_addr = bp_r - t - C4;  state_nxt = S_B4; end
      S_B4: begin
        acc_nxt = acc_r + t;
        mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_B5;
      end
      S_B5: begin
        mem_wr = 1'b1;  mem_addr = bp_r + t - C8;  mem_wdata = acc_r;
        state_nxt = S_D0;
      end
      // both neighbors free
      S_C0: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_C1; end
      S_C1: begin x_nxt = bp_r + t;  ret_nxt = S_C2;  state_nxt = S_P0; end
      S_C2: begin mem_rd = 1'b1;  mem_addr = bp_r - C8;  state_nxt = S_C3; end
      S_C3: begin x_nxt = bp_r - t;  ret_nxt = S_C4;  state_nxt = S_P0; end
      S_C4: begin mem_rd = 1'b1;  mem_addr = bp_r - C8;  state_nxt = S_C5; end
      S_C5: begin mem_rd = 1'b1;  mem_addr = bp_r - t - C4;  state_nxt = S_C6; end
      S_C6: begin
        tmp_nxt = t;
        mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_C7;
      end
      S_C7: begin
        x_nxt = bp_r + t;
        mem_rd = 1'b1;  mem_addr = bp_r + t - C4;  state_nxt = S_C8;
      end
      S_C8: begin mem_rd = 1'b1;  mem_addr = x_r + t - C8;  state_nxt = S_C9; end
      S_C9: begin acc_nxt = acc_r + tmp_r + t;  state_nxt = S_C10; end
      S_C10: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_C11; end
      S_C11: begin
        x_nxt = bp_r + t;
        mem_rd = 1'b1;  mem_addr = bp_r + t - C4;  state_nxt = S_C12;
      end
      S_C12: begin
        mem_wr = 1'b1;  mem_addr = x_r + t - C8;  mem_wdata = acc_r;
        state_nxt = S_D0;
      end
      // header of merged block at previous neighbor, then move bp there
      S_D0: begin mem_rd = 1'b1;  mem_addr = bp_r - C8;  state_nxt = S_D1; end
      S_D1: begin
        mem_wr = 1'b1;  mem_addr = bp_r - t - C4;  mem_wdata = acc_r;
        state_nxt = S_D2;
      end
      S_D2: begin mem_rd = 1'b1;  mem_addr = bp_r - C8;  state_nxt = S_D3; end
      S_D3: begin
        bp_nxt = bp_r - t;  x_nxt = bp_r - t;
        ret_nxt = S_MDONE;  state_nxt = S_Q0;
      end
      S_MDONE: begin
        state_nxt = (op_r == sfh_pkg::OP_ALLOC) ? S_K0 : S_DONE;
      end
      // unlink x from its class list
      S_P0: begin mem_rd = 1'b1;  mem_addr = x_r - C4;  state_nxt = S_P1; end
      S_P1: begin
        slot_nxt = AW'({class_of(t), 2'b00});
        mem_rd = 1'b1;  mem_addr = x_r;  state_nxt = S_P2;
      end
      S_P2: begin
        pre_nxt = mem_rdata;
        mem_rd = 1'b1;  mem_addr = x_r + C4;  state_nxt = S_P3;
      end
      S_P3: begin
        mem_wr = 1'b1;
        if (pre_r == '0 && mem_rdata == '0) begin
          mem_addr = slot_r;  state_nxt = ret_r;
        end else if (mem_rdata == '0) begin
          mem_addr = pre_r + C4;  state_nxt = ret_r;
        end else if (pre_r == '0) begin
          mem_addr = slot_r;  mem_wdata = mem_rdata;  state_nxt = S_P5;
        end else begin
          mem_addr = pre_r + C4;  mem_wdata = mem_rdata;  state_nxt = S_P7;
        end
      end
      S_P5: begin mem_rd = 1'b1;  mem_addr = x_r + C4;  state_nxt = S_P6; end
      S_P6: begin mem_wr = 1'b1;  mem_addr = mem_rdata;  state_nxt = ret_r; end
      S_P7: begin mem_rd = 1'b1;  mem_addr = x_r + C4;  state_nxt = S_P8; end
      S_P8: begin
        pre_nxt = mem_rdata;
        mem_rd = 1'b1;  mem_addr = x_r;  state_nxt = S_P9;
      end
      S_P9: begin
        mem_wr = 1'b1;  mem_addr = pre_r;  mem_wdata = mem_rdata;  state_nxt = ret_r;
      end
      // LIFO insert of x at its class head
      S_Q0: begin mem_rd = 1'b1;  mem_addr = x_r - C4;  state_nxt = S_Q1; end
      S_Q1: begin
        slot_nxt = AW'({class_of(t), 2'b00});
        mem_rd = 1'b1;  mem_addr = AW'({class_of(t), 2'b00});  state_nxt = S_Q2;
      end
      S_Q2: begin
        head_nxt = mem_rdata;
        mem_wr = 1'b1;  mem_addr = x_r + C4;  mem_wdata = mem_rdata;  state_nxt = S_Q3;
      end
      S_Q3: begin
        if (head_r != '0) begin
          mem_wr = 1'b1;  mem_addr = head_r;  mem_wdata = x_r;
        end
        state_nxt = S_Q4;
      end
      S_Q4: begin mem_wr = 1'b1;  mem_addr = x_r;  state_nxt = S_Q5; end
      S_Q5: begin
        mem_wr = 1'b1;  mem_addr = slot_r;  mem_wdata = x_r;  state_nxt = ret_r;
      end
      // first fit over the lists
      S_F0: begin
        mem_rd = 1'b1;  mem_addr = AW'({cls_r, 2'b00});  state_nxt = S_F1;
      end
      S_F1: begin
        bp_nxt = mem_rdata;
        if (mem_rdata == '0) begin
          if (cls_r == LAST_CLASS) begin
            state_nxt = S_NOFIT;
          end else begin
            cls_nxt = 5'(cls_r + 5'd1);
            mem_rd = 1'b1;  mem_addr = AW'({5'(cls_r + 5'd1), 2'b00});
          end
        end else if (budget_r == '0) begin
          state_nxt = S_NOFIT;
        end else begin
          budget_nxt = budget_r - BW'(1);
          mem_rd = 1'b1;  mem_addr = mem_rdata - C4;  state_nxt = S_F2;
        end
      end
      S_F2: begin
        if (t >= asize_r) begin
          state_nxt = S_K0;
        end else begin
          mem_rd = 1'b1;  mem_addr = bp_r + C4;  state_nxt = S_F1;
        end
      end
      S_NOFIT: begin
        bytes_nxt = {wp1[AW-3:1], 3'b000};
        state_nxt = S_G0;
      end
      // place: unlink, mark used, split off the tail when large enough
      S_K0: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_K1; end
      S_K1: begin
        csize_nxt = t;  res_nxt = bp_r[sfh_pkg::ADDR_W-1:0];
        x_nxt = bp_r;  ret_nxt = S_K2;  state_nxt = S_P0;
      end
      S_K2: begin
        split_nxt = (csize_r >= asize_r + C16);
        v_nxt = (csize_r >= asize_r + C16) ? (asize_r | C1) : (csize_r | C1);
        tmp_nxt = csize_r - asize_r;
        mem_wr = 1'b1;  mem_addr = bp_r - C4;
        mem_wdata = (csize_r >= asize_r + C16) ? (asize_r | C1) : (csize_r | C1);
        state_nxt = S_K3;
      end
      S_K3: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_K4; end
      S_K4: begin
        mem_wr = 1'b1;  mem_addr = bp_r + t - C8;  mem_wdata = v_r;
        state_nxt = split_r ? S_K5 : S_DONE;
      end
      S_K5: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_K6; end
      S_K6: begin
        bp_nxt = bp_r + t;
        mem_wr = 1'b1;  mem_addr = bp_r + t - C4;  mem_wdata = tmp_r;
        state_nxt = S_K7;
      end
      S_K7: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_K8; end
      S_K8: begin
        mem_wr = 1'b1;  mem_addr = bp_r + t - C8;  mem_wdata = tmp_r;
        x_nxt = bp_r;  ret_nxt = S_DONE;  state_nxt = S_Q0;
      end
      // free: clear used bits in header and footer
      S_R0: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_R1; end
      S_R1: begin
        acc_nxt = t;
        mem_wr = 1'b1;  mem_addr = bp_r - C4;  mem_wdata = t;  state_nxt = S_R2;
      end
      S_R2: begin mem_rd = 1'b1;  mem_addr = bp_r - C4;  state_nxt = S_R3; end
      S_R3: begin
        mem_wr = 1'b1;  mem_addr = bp_r + t - C8;  mem_wdata = acc_r;  state_nxt = S_M0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      top_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      top_r       <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;  op_r <= op_nxt;  bp_r <= bp_nxt;  x_r <= x_nxt;
    acc_r <= acc_nxt;  tmp_r <= tmp_nxt;  csize_r <= csize_nxt;  v_r <= v_nxt;
    slot_r <= slot_nxt;  pre_r <= pre_nxt;  head_r <= head_nxt;
    asize_r <= asize_nxt;  bytes_r <= bytes_nxt;  cls_r <= cls_nxt;  cnt_r <= cnt_nxt;
    budget_r <= budget_nxt;  pa_r <= pa_nxt;  split_r <= split_nxt;
    res_r <= res_nxt;  status_r <= status_nxt;
    out_addr_r <= out_addr_nxt;  out_status_r <= out_status_nxt;
  end

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd && mem_wr)) else $error("read and write in one cycle");
  a_top_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    top_r[2:0] == 3'b000) else $error("break not 8-byte aligned");
  a_top_limit: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= HEAP_W) else $error("break past heap limit");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside completion");
endmodule
`default_nettype wire

### design/segregated_fit_heap_allocator.sv
// Segregated-fit heap allocator: top level.
// Usage: requests arrive on in_ch (opcode, request_size, block_address) and
// each produces exactly one transaction on out_ch (result_address, status).
// One request is processed at a time; in_ch.ready is high while the
// sequencer is idle, even if a previous result still waits on out_ch.
// Blocks, list links and class heads live in one heap word memory (one access
// per cycle, registered read); the break is held in a register.
// Work per request, done through the memory accesses of the sequencer:
//   init : lays out class heads, prologue, epilogue; grows and coalesces.
//   alloc: visits list nodes and scans empty classes, then unlinks, splits
//          and inserts; when nothing fits, grows and coalesces first.
//   free : coalesces with whichever neighbors are free.
// A result waits in an output register while out_ch.ready is low; the
// sequencer holds in its completion step until that register is free.
// Reset (rst_n low, synchronous) clears the break, so the heap counts as
// uninitialized; the memory itself is not cleared and an init request is
// needed before allocate or free do real work.
`default_nettype none
module segregated_fit_heap_allocator #(
  parameter int HEAP_BYTES  = 1048576,
  parameter int CHUNK_BYTES = 4096
) (
  input wire logic clk,
  input wire logic rst_n,
  sfh_in_if.sink   in_ch,
  sfh_out_if.source out_ch
);
  localparam int L  = $clog2(HEAP_BYTES);
  localparam int AW = (L + 3 > 23) ? L + 3 : 23;

  logic          mem_rd, mem_wr;
  logic [AW-1:0] mem_addr, mem_wdata, mem_rdata;

  sfh_ctrl #(.HEAP_BYTES(HEAP_BYTES), .CHUNK_BYTES(CHUNK_BYTES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_opcode  (in_ch.opcode),
    .in_size    (in_ch.request_size),
    .in_addr    (in_ch.block_address),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_addr   (out_ch.result_address),
    .out_status (out_ch.status),
    .mem_rd     (mem_rd),
    .mem_wr     (mem_wr),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  sfh_heap_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
    .clk   (clk),
    .rd_en (mem_rd),
    .wr_en (mem_wr),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );
endmodule
`default_nettype wire
